@@ src/ddo_pkg.sv @@
package ddo_pkg;

    localparam int CordicSteps = 16;
    localparam int AtanEntries = 24;
    localparam int StepRuns    = (CordicSteps < AtanEntries) ? CordicSteps : AtanEntries;
    localparam int StepW       = $clog2(AtanEntries + 1);
    localparam logic [33:0] CordicGain = 34'd652032874;
    localparam logic [15:0] ResetDistance = 16'd1001;
    localparam logic [15:0] ResetTurn     = 16'd3123;
    localparam logic [15:0] SerialBits    = 16;
    localparam int BitCntW = 5;

    localparam logic RegDistance = 1'b0;
    localparam logic RegTurn     = 1'b1;

    typedef struct packed {
        logic signed [15:0] left_counts;
        logic signed [15:0] right_counts;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] heading;
        logic signed [31:0] travel;
        logic signed [15:0] turn;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ROT,
        S_POS,
        S_ADD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_unit_ctl;

    function automatic logic [31:0] atan_at(input logic [StepW-1:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ src/ddo_sermul.sv @@
module ddo_sermul
    import ddo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [33:0] i_a,
    input  logic [16:0]        i_b,
    input  logic               i_b_neg,
    output logic               o_done,
    output logic signed [66:0] o_p
);
    // Shift-add multiplier: one bit of the magnitude i_b per cycle.
    logic signed [66:0] r_acc, n_acc;
    logic signed [66:0] r_a, n_a;
    logic [16:0]        r_b, n_b;
    logic               r_neg, n_neg;
    logic [BitCntW-1:0] r_cnt, n_cnt;
    logic               r_run, n_run;
    logic               r_done, n_done;

    always_comb begin
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        if (i_start) begin
            n_acc = '0;
            n_a   = 67'(i_a);
            n_b   = i_b;
            n_neg = i_b_neg;
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = r_a <<< 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == BitCntW'(16)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
                if (r_neg) begin
                    n_acc = -((r_b[0]) ? (r_acc + r_a) : r_acc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

@@ src/ddo_cordic.sv @@
module ddo_cordic
    import ddo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_angle,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    logic signed [33:0] r_x, n_x, r_y, n_y;
    logic signed [33:0] r_z, n_z;
    logic               r_flip, n_flip;
    logic [StepW-1:0]   r_i, n_i;
    logic               r_run, n_run, r_done, n_done;
    logic signed [33:0] z0;
    logic signed [33:0] xs, ys, at;

    always_comb begin
        z0 = 34'(i_angle) <<< 16;
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        at = 34'(atan_at(r_i));
        n_x = r_x; n_y = r_y; n_z = r_z; n_flip = r_flip; n_i = r_i;
        n_run = r_run; n_done = 1'b0;
        if (i_start) begin
            n_x = CordicGain;
            n_y = '0;
            n_i = '0;
            n_run = 1'b1;
            n_flip = 1'b0;
            n_z = z0;
            if (z0 > 34'sd1073741824) begin
                n_z = z0 - 34'sd2147483648; n_flip = 1'b1;
            end else if (z0 < -34'sd1073741824) begin
                n_z = z0 + 34'sd2147483648; n_flip = 1'b1;
            end
        end else if (r_run) begin
            if (r_i == StepW'(StepRuns)) begin
                n_run = 1'b0;
                n_done = 1'b1;
                if (r_flip) begin
                    n_x = -r_x; n_y = -r_y;
                end
            end else begin
                if (!r_z[33]) begin
                    n_x = r_x - ys; n_y = r_y + xs; n_z = r_z - at;
                end else begin
                    n_x = r_x + ys; n_y = r_y - xs; n_z = r_z + at;
                end
                n_i = r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z; r_flip <= n_flip; r_i <= n_i;
        if (!i_rst_n) begin
            r_run <= 1'b0; r_done <= 1'b0;
        end else begin
            r_run <= n_run; r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_x;
    assign o_sin  = r_y;
endmodule

@@ src/differential_drive_odometry.sv @@
// Channel  Direction  Handshake                Payload
// in       input      i_valid / o_stall        t_in_item  (left, right counts)
// out      output     o_valid / i_stall        t_out_item (pose, heading, travel, turn)
// cfg      input      i_cfg_valid/o_cfg_ready  index, 16-bit data
// A request is taken only when idle. Each one runs through four shift-add multiplies
// (travel, turn, dx, dy) with the CORDIC loop between turn and dx, then a step to
// update the heading and one to load the result.
// Reset clears the pose and heading and loads the default register values.
// A result waits in the output register until taken; the next request is processed
// meanwhile, but its result holds the block busy until the first one leaves.
module differential_drive_odometry
    import ddo_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    t_state r_state, n_state;
    logic [15:0] r_cdist, r_cturn;
    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_head;
    logic signed [16:0] r_dif;
    logic signed [31:0] r_travel;
    logic signed [15:0] r_turn;
    logic [1:0]  r_phase;
    logic signed [33:0] r_cos, r_sin;
    logic        r_oval;
    t_out_item   r_out;

    logic        in_acc, mul_start, cor_start, mul_done, cor_done;
    logic signed [33:0] mul_a, cos_w, sin_w;
    logic [16:0] mul_b;
    logic        mul_neg;
    logic [1:0]  mul_sel;
    logic signed [66:0] mul_p;
    logic signed [15:0] mid;
    logic signed [15:0] turn_w;
    logic signed [16:0] in_sum;

    assign in_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !r_oval;
    assign in_sum = 17'(i_data.left_counts) + 17'(i_data.right_counts);
    assign turn_w = 16'(mul_p >>> 8);
    // The CORDIC takes its angle at the edge where the turn product is finished.
    assign mid = r_head + (turn_w >>> 1);
    assign mul_sel = (r_state == S_IDLE) ? 2'd0 : r_phase + 2'd1;

    ddo_sermul u_mul (
        .i_clk, .i_rst_n, .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
        .i_b_neg(mul_neg), .o_done(mul_done), .o_p(mul_p)
    );
    ddo_cordic u_cor (
        .i_clk, .i_rst_n, .i_start(cor_start), .i_angle(mid), .o_done(cor_done),
        .o_cos(cos_w), .o_sin(sin_w)
    );

    // Phase 0 travel, 1 turn, 2 dx, 3 dy share the multiplier.
    always_comb begin
        mul_a = '0; mul_b = '0; mul_neg = 1'b0;
        case (mul_sel)
            2'd0: begin
                mul_a = 34'(r_cdist); mul_b = in_sum[16] ? 17'(-in_sum) : 17'(in_sum);
                mul_neg = in_sum[16];
            end
            2'd1: begin
                mul_a = 34'(r_cturn); mul_b = r_dif[16] ? 17'(-r_dif) : 17'(r_dif);
                mul_neg = r_dif[16];
            end
            2'd2: begin
                mul_a = cos_w; mul_b = r_travel[31] ? 17'(-(r_travel >>> 16))
                                                    : 17'(r_travel >>> 16);
                mul_neg = 1'b0;
            end
            default: begin
                mul_a = r_sin; mul_b = r_travel[31] ? 17'(-(r_travel >>> 16))
                                                    : 17'(r_travel >>> 16);
                mul_neg = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_MUL;
            S_MUL:  if (mul_done && r_phase == 2'd1) n_state = S_ROT;
            S_ROT:  if (cor_done) n_state = S_POS;
            S_POS:  if (mul_done && r_phase == 2'd3) n_state = S_ADD;
            S_ADD:  n_state = S_OUT;
            S_OUT:  if (!r_oval || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_start = 1'b0;
        cor_start = 1'b0;
        case (r_state)
            S_IDLE: mul_start = in_acc;
            S_MUL:  begin
                mul_start = mul_done && r_phase == 2'd0;
                cor_start = mul_done && r_phase == 2'd1;
            end
            S_ROT:  mul_start = cor_done;
            S_POS:  mul_start = mul_done && r_phase == 2'd2;
            default: mul_start = 1'b0;
        endcase
    end

    // The serial multiplier covers the signed upper half of travel; the unsigned
    // lower 16 bits are multiplied directly and added in.
    logic signed [66:0] low_p;
    assign low_p = ((r_phase == 2'd2) ? r_cos : r_sin) * $signed({1'b0, r_travel[15:0]});

    logic signed [66:0] full_p;
    logic signed [66:0] hi_p;
    always_comb begin
        hi_p = r_travel[31] ? -mul_p : mul_p;
        full_p = (hi_p <<< 16) + low_p;
    end

    logic signed [32:0] fx, fy;
    logic signed [31:0] fsx, fsy;
    always_comb begin
        fx = 33'(r_px) + 33'(full_p >>> 30);
        fy = 33'(r_py) + 33'(full_p >>> 30);
        fsx = 32'(fx);
        fsy = 32'(fy);
        if ((full_p >>> 30) + 67'(r_px) > 67'sd2147483647) fsx = 32'h7fffffff;
        else if ((full_p >>> 30) + 67'(r_px) < -67'sd2147483648) fsx = 32'h80000000;
        if ((full_p >>> 30) + 67'(r_py) > 67'sd2147483647) fsy = 32'h7fffffff;
        else if ((full_p >>> 30) + 67'(r_py) < -67'sd2147483648) fsy = 32'h80000000;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dif <= 17'(i_data.right_counts) - 17'(i_data.left_counts);
        end
        if (r_state == S_MUL && mul_done) begin
            if (r_phase == 2'd0) r_travel <= 32'(mul_p >>> 1);
            else r_turn <= turn_w;
        end
        if (cor_done) begin
            r_cos <= cos_w;
            r_sin <= sin_w;
        end
        if (r_state == S_OUT && (!r_oval || !i_stall)) begin
            r_out.pose_x  <= r_px;
            r_out.pose_y  <= r_py;
            r_out.heading <= r_head;
            r_out.travel  <= r_travel;
            r_out.turn    <= r_turn;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 2'd0;
            r_cdist <= ResetDistance;
            r_cturn <= ResetTurn;
            r_px <= '0; r_py <= '0; r_head <= '0;
            r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == RegDistance) r_cdist <= i_cfg_data;
                else r_cturn <= i_cfg_data;
            end
            if (mul_start) r_phase <= mul_sel;
            if (r_state == S_POS && mul_done) begin
                if (r_phase == 2'd2) r_px <= fsx;
                else r_py <= fsy;
            end
            if (r_state == S_ADD) r_head <= r_head + r_turn;
            if (r_state == S_OUT && (!r_oval || !i_stall)) r_oval <= 1'b1;
            else if (r_oval && !i_stall) r_oval <= 1'b0;
        end
    end

    assign o_valid = r_oval;
    always_comb begin
        o_data = r_out;
        o_data.heading = r_out.heading;
    end

`ifndef ASSERT_OFF
    a_no_input_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("input taken while busy");
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_done && cor_done)) else $error("multiplier and cordic finish together");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_data)) else $error("stalled result changed");
`endif
endmodule
